/* rtl/core/pcmv_pkg.sv */
// Package for the per-channel statistics block: constants, payload types and state codes.
package pcmv_pkg;

   localparam int STORE_DEPTH = 65536;
   localparam int MAX_ATTRS   = 4;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W       = 40;
   localparam int SQ_W        = 50;
   localparam int DIV_W       = SQ_W + 32;
   localparam int DIVC_W      = 7;

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_P2RD   = 4'd1;
   localparam logic [3:0] S_P2WT   = 4'd2;
   localparam logic [3:0] S_P2MUL  = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_P2SQ   = 4'd5;
   localparam logic [3:0] S_P2ACC  = 4'd6;
   localparam logic [3:0] S_FIN    = 4'd7;
   localparam logic [3:0] S_MEANDN = 4'd8;
   localparam logic [3:0] S_VARDN  = 4'd9;
   localparam logic [3:0] S_SQST   = 4'd10;
   localparam logic [3:0] S_SQRT   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   localparam logic [0:0] REG_ATTR_COUNT = 1'd0;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic [1:0]         attr_index;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         attr_out;
      logic signed [15:0] min_value;
      logic signed [15:0] max_value;
      logic signed [31:0] mean_fixed;
      logic [47:0]        variance_fixed;
      logic [31:0]        std_dev_fixed;
      logic               empty_set;
      logic               last_result;
   } rsp_type;

endpackage

/* rtl/core/per_channel_mean_variance_min_max.sv */
// Top level: sample store, two-pass per-attribute statistics and APB register port.
// Samples are taken one per cycle while the block is loading. After the item marked
// last the block stops taking items: the second pass reads the sample store one
// entry at a time, and for each stored sample the serial divider (33 steps) forms its
// truncated deviation. Each non-empty attribute's result then needs three divisions of
// 48, 66 and 82 steps in the same one-bit-a-cycle divider and a 32-step square root.
// Loading resumes once the last result sits in the output register. The store needs no
// clearing pass.
module per_channel_mean_variance_min_max (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcmv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcmv_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import pcmv_pkg::*;

   logic [ADDR_W+1:0] store [STORE_DEPTH];
   logic [ADDR_W+1:0] mem_rd_ff;
   logic              mem_we;
   logic              mem_re;

   logic [3:0]        state_ff, state_in;
   logic [2:0]        attr_count_ff, attr_count_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [1:0]        t_ff, t_in;
   logic [1:0]        j_ff, j_in;

   logic signed [SUM_W-1:0] sum_ff [MAX_ATTRS];
   logic signed [SUM_W-1:0] sum_in [MAX_ATTRS];
   logic signed [15:0]      min_ff [MAX_ATTRS];
   logic signed [15:0]      min_in [MAX_ATTRS];
   logic signed [15:0]      max_ff [MAX_ATTRS];
   logic signed [15:0]      max_in [MAX_ATTRS];
   logic [CNT_W-1:0]        n_ff   [MAX_ATTRS];
   logic [CNT_W-1:0]        n_in   [MAX_ATTRS];
   logic [SQ_W-1:0]         sq_ff  [MAX_ATTRS];
   logic [SQ_W-1:0]         sq_in  [MAX_ATTRS];

   logic signed [CNT_W+16:0] prod_ff, prod_in;
   logic [31:0]              sqd_ff, sqd_in;

   logic [DIV_W-1:0]  div_num_ff, div_num_in;
   logic [CNT_W-1:0]  div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]  div_den_ff, div_den_in;
   logic [63:0]       div_quo_ff, div_quo_in;
   logic [DIVC_W-1:0] div_cnt_ff, div_cnt_in;
   logic [3:0]        div_next_ff, div_next_in;

   logic [63:0]       sx_ff, sx_in;
   logic [63:0]       sres_ff, sres_in;
   logic [63:0]       sbit_ff, sbit_in;

   logic [31:0]       mean_ff, mean_in;
   logic [47:0]       var_ff, var_in;
   logic [31:0]       std_ff, std_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [2:0]              na;
   logic [1:0]              sel;
   logic signed [SUM_W-1:0] sum_r;
   logic signed [15:0]      min_r, max_r;
   logic [CNT_W-1:0]        n_r;
   logic [SQ_W-1:0]         sq_r;
   logic signed [15:0]      x;
   logic                    accept, store_ok;
   logic signed [SUM_W:0]   diff;
   logic [SUM_W:0]          diff_mag;
   logic [SUM_W-1:0]        sum_abs;
   logic [CNT_W:0]          div_t;
   logic                    div_ge;
   logic [63:0]             s_sum;
   logic                    out_free;
   logic                    cfg_we;

   assign na         = (attr_count_ff == 3'd4 && MAX_ATTRS >= 4) ? 3'd4 : 3'd1;
   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_LOAD);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_ATTR_COUNT;
   assign csr_prdata = (csr_paddr[2] == REG_ATTR_COUNT) ? {29'd0, attr_count_ff} : 32'd0;
   assign attr_count_in = cfg_we ? csr_pwdata[2:0] : attr_count_ff;

   always_comb begin
      if (state_ff == S_LOAD) begin
         sel = req_data.attr_index;
      end else if (state_ff == S_P2WT) begin
         sel = mem_rd_ff[ADDR_W+1:ADDR_W];
      end else if (state_ff == S_FIN || state_ff == S_MEANDN || state_ff == S_VARDN ||
                   state_ff == S_SQST || state_ff == S_SQRT || state_ff == S_OUT) begin
         sel = j_ff;
      end else begin
         sel = t_ff;
      end
   end

   assign sum_r    = sum_ff[sel];
   assign min_r    = min_ff[sel];
   assign max_r    = max_ff[sel];
   assign n_r      = n_ff[sel];
   assign sq_r     = sq_ff[sel];
   assign x        = req_data.sample_value;
   assign store_ok = ({1'b0, req_data.attr_index} < na) &&
                     (count_ff < CNT_W'(STORE_DEPTH));
   assign mem_we   = accept && store_ok;
   assign mem_re   = (state_ff == S_P2RD) && (idx_ff != count_ff);
   assign diff     = (SUM_W+1)'(sum_r) - (SUM_W+1)'(prod_ff);
   assign diff_mag = diff[SUM_W] ? (SUM_W+1)'(-diff) : (SUM_W+1)'(diff);
   assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
   assign div_t    = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_ge   = div_t >= {1'b0, div_den_ff};
   assign s_sum    = sres_ff + sbit_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      n_in         = n_ff;
      sq_in        = sq_ff;
      prod_in      = prod_ff;
      sqd_in       = sqd_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      div_next_in  = div_next_ff;
      sx_in        = sx_ff;
      sres_in      = sres_ff;
      sbit_in      = sbit_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      std_in       = std_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (store_ok) begin
                  count_in = count_ff + 1'b1;
                  if (n_r == '0 || x < min_r) begin
                     min_in[sel] = x;
                  end
                  if (n_r == '0 || x > max_r) begin
                     max_in[sel] = x;
                  end
                  sum_in[sel] = sum_r + SUM_W'(x);
                  n_in[sel]   = n_r + 1'b1;
               end
               if (req_data.last_sample) begin
                  idx_in   = '0;
                  state_in = S_P2RD;
               end
            end
         end
         S_P2RD: begin
            if (idx_ff == count_ff) begin
               j_in     = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_P2WT;
            end
         end
         S_P2WT: begin
            if ({1'b0, sel} >= na || n_r == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_P2RD;
            end else begin
               t_in     = sel;
               prod_in  = (CNT_W+17)'($signed(mem_rd_ff[15:0]) * $signed({1'b0, n_r}));
               state_in = S_P2MUL;
            end
         end
         S_P2MUL: begin
            div_num_in  = {diff_mag[32:0], (DIV_W-33)'(0)};
            div_rem_in  = '0;
            div_quo_in  = '0;
            div_den_in  = n_r;
            div_cnt_in  = DIVC_W'(33);
            div_next_in = S_P2SQ;
            state_in    = S_DIV;
         end
         S_DIV: begin
            div_num_in = {div_num_ff[DIV_W-2:0], 1'b0};
            div_rem_in = div_ge ? CNT_W'(div_t - {1'b0, div_den_ff}) : div_t[CNT_W-1:0];
            div_quo_in = {div_quo_ff[62:0], div_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DIVC_W'(1)) begin
               state_in = div_next_ff;
            end
         end
         S_P2SQ: begin
            sqd_in   = div_quo_ff[15:0] * div_quo_ff[15:0];
            state_in = S_P2ACC;
         end
         S_P2ACC: begin
            sq_in[sel] = sq_r + SQ_W'(sqd_ff);
            idx_in     = idx_ff + 1'b1;
            state_in   = S_P2RD;
         end
         S_FIN: begin
            if (n_r == '0) begin
               state_in = S_OUT;
            end else begin
               div_num_in  = {sum_abs[31:0], 16'd0, (DIV_W-48)'(0)};
               div_rem_in  = '0;
               div_quo_in  = '0;
               div_den_in  = n_r;
               div_cnt_in  = DIVC_W'(48);
               div_next_in = S_MEANDN;
               state_in    = S_DIV;
            end
         end
         S_MEANDN: begin
            mean_in     = sum_r[SUM_W-1] ? 32'(-div_quo_ff[31:0]) : div_quo_ff[31:0];
            div_num_in  = {sq_r, 16'd0, (DIV_W-SQ_W-16)'(0)};
            div_rem_in  = '0;
            div_quo_in  = '0;
            div_cnt_in  = DIVC_W'(SQ_W + 16);
            div_next_in = S_VARDN;
            state_in    = S_DIV;
         end
         S_VARDN: begin
            var_in      = div_quo_ff[47:0];
            div_num_in  = {sq_r, 32'd0};
            div_rem_in  = '0;
            div_quo_in  = '0;
            div_cnt_in  = DIVC_W'(DIV_W);
            div_next_in = S_SQST;
            state_in    = S_DIV;
         end
         S_SQST: begin
            sx_in    = div_quo_ff;
            sres_in  = '0;
            sbit_in  = 64'd1 << 62;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sbit_ff == '0) begin
               std_in   = sres_ff[31:0];
               state_in = S_OUT;
            end else begin
               if (sx_ff >= s_sum) begin
                  sx_in   = sx_ff - s_sum;
                  sres_in = (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_in = sres_ff >> 1;
               end
               sbit_in = sbit_ff >> 2;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.attr_out    = j_ff;
               rsp_in.last_result = ({1'b0, j_ff} == na - 3'd1);
               rsp_in.empty_set   = (n_r == '0);
               if (n_r == '0) begin
                  rsp_in.min_value      = '0;
                  rsp_in.max_value      = '0;
                  rsp_in.mean_fixed     = '0;
                  rsp_in.variance_fixed = '0;
                  rsp_in.std_dev_fixed  = '0;
               end else begin
                  rsp_in.min_value      = min_r;
                  rsp_in.max_value      = max_r;
                  rsp_in.mean_fixed     = mean_ff;
                  rsp_in.variance_fixed = var_ff;
                  rsp_in.std_dev_fixed  = std_ff;
               end
               if ({1'b0, j_ff} == na - 3'd1) begin
                  count_in = '0;
                  for (int k = 0; k < MAX_ATTRS; k++) begin
                     sum_in[k] = '0;
                     min_in[k] = '0;
                     max_in[k] = '0;
                     n_in[k]   = '0;
                     sq_in[k]  = '0;
                  end
                  state_in = S_LOAD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_FIN;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[count_ff[ADDR_W-1:0]] <= {req_data.attr_index, x};
      end
      if (mem_re) begin
         mem_rd_ff <= store[idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         attr_count_ff <= 3'd1;
         count_ff      <= '0;
         idx_ff        <= '0;
         t_ff          <= '0;
         j_ff          <= '0;
         div_cnt_ff    <= '0;
         div_next_ff   <= S_LOAD;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < MAX_ATTRS; k++) begin
            sum_ff[k] <= '0;
            min_ff[k] <= '0;
            max_ff[k] <= '0;
            n_ff[k]   <= '0;
            sq_ff[k]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         attr_count_ff <= attr_count_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         t_ff          <= t_in;
         j_ff          <= j_in;
         div_cnt_ff    <= div_cnt_in;
         div_next_ff   <= div_next_in;
         rsp_valid_ff  <= rsp_valid_in;
         sum_ff        <= sum_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         n_ff          <= n_in;
         sq_ff         <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      sqd_ff     <= sqd_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_quo_ff <= div_quo_in;
      sx_ff      <= sx_in;
      sres_ff    <= sres_in;
      sbit_ff    <= sbit_in;
      mean_ff    <= mean_in;
      var_ff     <= var_in;
      std_ff     <= std_in;
      rsp_ff     <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("sample count beyond store depth");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_cnt_ff != DIVC_W'(33) |-> div_rem_ff < div_den_ff)
      else $error("divider remainder not below divisor");
   a_last_attr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && out_free && {1'b0, j_ff} == na - 3'd1 |=> state_ff == S_LOAD)
      else $error("loading not resumed after final result");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for the per-attribute min/max/mean/variance statistics block.
module testbench;
   import pcmv_pkg::*;

   localparam int CLK_LIMIT = 2000000;
   localparam int DRAIN_GAP = 400;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   per_channel_mean_variance_min_max dut (.*);

   // predictor state
   bit [2:0]           attr_count_reg;
   bit signed [15:0]   held_value[$];
   bit [1:0]           held_attr[$];
   longint             attr_total[4];
   bit signed [15:0]   attr_lo[4], attr_hi[4];
   int                 attr_samples[4];
   rsp_type            stats_expected[$];

   int errors, items_sent, sets_sent, results_seen, cycle_count;
   int send_idle_pct, recv_idle_pct, hold_cycles;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CLK_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock)
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

   always @(negedge clock) begin
      if (reset || hold_cycles > 0) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic bit [63:0] root64(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void clear_set();
      held_value.delete();
      held_attr.delete();
      for (int k = 0; k < 4; k++) begin
         attr_total[k] = 0;
         attr_lo[k] = 0;
         attr_hi[k] = 0;
         attr_samples[k] = 0;
      end
   endfunction

   function automatic void predict_stats(req_type it);
      int na;
      longint n, d;
      bit [63:0] sq[4], mag, m, q, r, var_q, v32, rt;
      rsp_type res;
      na = (attr_count_reg == 3'd4) ? 4 : 1;
      if (it.attr_index < na && held_value.size() < STORE_DEPTH) begin
         if (attr_samples[it.attr_index] == 0 || it.sample_value < attr_lo[it.attr_index])
            attr_lo[it.attr_index] = it.sample_value;
         if (attr_samples[it.attr_index] == 0 || it.sample_value > attr_hi[it.attr_index])
            attr_hi[it.attr_index] = it.sample_value;
         held_value.push_back(it.sample_value);
         held_attr.push_back(it.attr_index);
         attr_total[it.attr_index] += it.sample_value;
         attr_samples[it.attr_index]++;
      end
      if (!it.last_sample) return;
      for (int k = 0; k < 4; k++) sq[k] = 0;
      foreach (held_value[i]) begin
         if (held_attr[i] >= na) continue;
         n = attr_samples[held_attr[i]];
         d = (attr_total[held_attr[i]] - longint'(held_value[i]) * n) / n;
         sq[held_attr[i]] += d * d;
      end
      for (int j = 0; j < na; j++) begin
         res = '0;
         res.attr_out = 2'(j);
         res.last_result = (j + 1 == na);
         if (attr_samples[j] == 0) begin
            res.empty_set = 1'b1;
         end else begin
            n = attr_samples[j];
            mag = attr_total[j] < 0 ? -attr_total[j] : attr_total[j];
            m = (mag << 16) / n;
            if (attr_total[j] < 0) m = -m;
            q = sq[j] / n;
            r = sq[j] % n;
            var_q = (q << 16) + ((r << 16) / n);
            v32 = (q << 32) + ((r << 32) / n);
            rt = root64(v32);
            res.min_value = attr_lo[j];
            res.max_value = attr_hi[j];
            res.mean_fixed = m[31:0];
            res.variance_fixed = var_q[47:0];
            res.std_dev_fixed = rt[31:0];
         end
         stats_expected.push_back(res);
      end
      clear_set();
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (stats_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %p", $time, rsp_data);
         end else begin
            rsp_type e;
            e = stats_expected.pop_front();
            if (e.attr_out !== rsp_data.attr_out || e.min_value !== rsp_data.min_value ||
                e.max_value !== rsp_data.max_value || e.mean_fixed !== rsp_data.mean_fixed ||
                e.variance_fixed !== rsp_data.variance_fixed ||
                e.std_dev_fixed !== rsp_data.std_dev_fixed ||
                e.empty_set !== rsp_data.empty_set || e.last_result !== rsp_data.last_result)
            begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
            end
         end
      end
   end

   task automatic send_sample(logic signed [15:0] v, logic [1:0] a, logic lst);
      req_type it;
      if (req_valid && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      it.sample_value = v;
      it.attr_index = a;
      it.last_sample = lst;
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_stats(it);
      items_sent++;
      if (lst) sets_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (stats_expected.size() == 0);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_attr_count(logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * REG_ATTR_COUNT);
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      attr_count_reg = v[2:0];
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {29'd0, attr_count_reg}) begin
         errors++;
         $display("%0t: attr_count read expected %0d actual %0d",
                  $time, attr_count_reg, csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(15)) - 8);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic test_extremes();
      write_attr_count(1);
      send_sample(16'sh7fff, 0, 0);
      send_sample(16'sh8000, 0, 0);
      send_sample(16'sh0000, 0, 0);
      send_sample(16'shffff, 0, 1);
      send_sample(16'sh5555, 0, 1);              // single sample
      send_sample(16'shaaaa, 2, 1);              // ignored attribute, empty set
      send_sample(16'sh8000, 0, 0);
      send_sample(16'sh8000, 3, 0);              // ignored
      send_sample(16'sh8000, 0, 1);
   endtask

   task automatic test_four_attrs();
      wait_drained();
      write_attr_count(4);
      send_sample(16'sh7fff, 3, 0);
      send_sample(16'sh8000, 3, 0);
      send_sample(-16'sd3, 1, 0);
      send_sample(16'sd4, 1, 1);                 // attrs 0 and 2 empty
      send_sample(16'sd9, 0, 1);
      send_sample(16'sd1, 2, 1);
   endtask

   task automatic test_other_counts();
      wait_drained();
      write_attr_count(0);
      send_sample(16'sd100, 1, 0);               // ignored in one-attribute mode
      send_sample(-16'sd100, 0, 1);
      wait_drained();
      write_attr_count(7);
      send_sample(16'sd7, 0, 0);
      send_sample(-16'sd2, 0, 1);
      wait_drained();
      write_attr_count(2);
      send_sample(16'sd13, 0, 1);
   endtask

   task automatic test_random_sets(int n_items, bit with_pressure);
      int target, len, na;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(2) == 0) begin
            wait_drained();
            case ($urandom_range(5))
               0, 1, 2: write_attr_count(4);
               3: write_attr_count(1);
               default: write_attr_count($urandom_range(7));
            endcase
         end
         if (with_pressure && $urandom_range(3) == 0) hold_cycles = 3000;
         na = (attr_count_reg == 3'd4) ? 4 : 1;
         len = ($urandom_range(15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            logic [1:0] a;
            a = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(na - 1));
            send_sample(pick_value(), a, i == len - 1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      attr_count_reg = 3'd1;
      clear_set();
      send_idle_pct = 24;
      recv_idle_pct = 77;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_four_attrs();
      test_other_counts();
      test_random_sets(130, 0);
      send_idle_pct = 77;
      recv_idle_pct = 24;
      test_random_sets(130, 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sets(130, 1);
      wait_drained();

      $display("%0d items in %0d data sets, %0d results checked, %0d errors",
               items_sent, sets_sent, results_seen, errors);
      $display("attribute counts 0..7, extremes, empty sets, stalls and hold-off covered");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
